/* design/bmf_pkg.sv */
// shared constants, types and codes of the bounded message fifo
package bmf_pkg;

  localparam int DEPTH  = 16;
  localparam int ELEMSZ = 64;

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;
  localparam int ADDR_W = (DEPTH * ELEMSZ > 1) ? $clog2(DEPTH * ELEMSZ) : 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_LEN,
    S_RD_BYTE
  } state_t;

  typedef struct packed {
    logic wr_item;
    logic rd_start;
    logic rd_len_load;
    logic rd_emit;
    logic empty_emit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic out_free;
    logic rd_last;
  } stat_t;

endpackage

/* design/bmf_ram.sv */
// generic simple dual-port ram with registered read
module bmf_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/bmf_ctrl.sv */
// controller state machine of the bounded message fifo
module bmf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_op,
  output logic           in_stall,
  input  bmf_pkg::stat_t stat,
  output bmf_pkg::cmd_t  cmd
);
  import bmf_pkg::*;

  state_t state_r, state_nxt;
  logic   take;

  assign take     = (state_r == S_IDLE) && in_valid && stat.out_free;
  assign in_stall = !((state_r == S_IDLE) && stat.out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take && (in_op == OP_READ) && !stat.empty) begin
          state_nxt = S_RD_LEN;
        end
      end
      S_RD_LEN: begin
        state_nxt = S_RD_BYTE;
      end
      S_RD_BYTE: begin
        if (stat.out_free && stat.rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.wr_item    = take && (in_op == OP_WRITE);
        cmd.rd_start   = take && (in_op == OP_READ) && !stat.empty;
        cmd.empty_emit = take && (in_op == OP_READ) && stat.empty;
      end
      S_RD_LEN: begin
        cmd.rd_len_load = 1'b1;
      end
      S_RD_BYTE: begin
        cmd.rd_emit = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* design/bmf_dpath.sv */
// datapath: slot pointers, message stores and the result register
module bmf_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bmf_pkg::cmd_t                cmd,
  output bmf_pkg::stat_t               stat,
  input  logic [bmf_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                         in_byte_present,
  input  logic                         in_end_of_message,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic                         out_is_read_data,
  output logic [bmf_pkg::BYTE_W-1:0]   out_data_byte_out,
  output logic                         out_byte_valid,
  output logic [bmf_pkg::LEN_W-1:0]    out_length,
  output logic                         out_last
);
  import bmf_pkg::*;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
    slot_base = ADDR_W'(s) * ADDR_W'(ELEMSZ);
  endfunction

  logic [SLOT_W-1:0] read_slot_r, write_slot_r;
  logic [CNT_W-1:0]  entries_held_r;
  logic [LEN_W-1:0]  write_offset_r;
  logic              dropping_r;
  logic [LEN_W-1:0]  rd_len_r;
  logic [LEN_W-1:0]  rd_idx_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic              out_is_read_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_byte_valid_r;
  logic [LEN_W-1:0]  out_length_r;
  logic              out_last_r;

  logic              full, drop, store, commit, rd_last, out_free, load;
  logic [LEN_W-1:0]  offset_inc, len_clamped, rd_off;
  logic [LEN_W-1:0]  len_rd_data;
  logic [BYTE_W-1:0] byte_rd_data;
  logic [ADDR_W-1:0] byte_wr_addr, byte_rd_addr;
  logic              byte_rd_en;

  status_t           ld_status;
  logic              ld_is_read, ld_byte_valid, ld_last;
  logic [BYTE_W-1:0] ld_byte;
  logic [LEN_W-1:0]  ld_length;

  // write side
  assign full       = (entries_held_r == CNT_W'(DEPTH));
  assign drop       = dropping_r || full;
  assign store      = !drop && in_byte_present && (write_offset_r < LEN_W'(ELEMSZ));
  assign offset_inc = write_offset_r + LEN_W'(store);
  assign commit     = !drop && in_end_of_message;
  assign byte_wr_addr = slot_base(write_slot_r) + ADDR_W'(write_offset_r);

  // read side
  assign len_clamped = (len_rd_data > LEN_W'(ELEMSZ)) ? LEN_W'(ELEMSZ) : len_rd_data;
  assign rd_last     = (rd_len_r == '0) || ((rd_idx_r + 1'b1) == rd_len_r);
  assign rd_off      = cmd.rd_len_load ? '0 : rd_idx_r + 1'b1;
  assign byte_rd_addr = slot_base(read_slot_r) + ADDR_W'(rd_off);
  assign byte_rd_en  = cmd.rd_len_load || (cmd.rd_emit && !rd_last);

  bmf_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH * ELEMSZ)) u_byte_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_item && store),
    .wr_addr (byte_wr_addr),
    .wr_data (in_data_byte),
    .rd_en   (byte_rd_en),
    .rd_addr (byte_rd_addr),
    .rd_data (byte_rd_data)
  );

  bmf_ram #(.WIDTH(LEN_W), .DEPTH(DEPTH)) u_len_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_item && commit),
    .wr_addr (write_slot_r),
    .wr_data (offset_inc),
    .rd_en   (cmd.rd_start),
    .rd_addr (read_slot_r),
    .rd_data (len_rd_data)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign load     = (cmd.wr_item && in_end_of_message) || cmd.empty_emit || cmd.rd_emit;

  always_comb begin
    ld_status     = ST_OK;
    ld_is_read    = 1'b0;
    ld_byte       = '0;
    ld_byte_valid = 1'b0;
    ld_length     = '0;
    ld_last       = 1'b1;
    if (cmd.empty_emit) begin
      ld_status = ST_EMPTY;
    end else if (cmd.rd_emit) begin
      ld_is_read = 1'b1;
      if (rd_len_r != '0) begin
        ld_byte       = byte_rd_data;
        ld_byte_valid = 1'b1;
        ld_length     = rd_len_r;
        ld_last       = rd_last;
      end
    end else if (drop) begin
      ld_status = ST_FULL;
    end else begin
      ld_length = offset_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_slot_r    <= '0;
      write_slot_r   <= '0;
      entries_held_r <= '0;
      write_offset_r <= '0;
      dropping_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cmd.wr_item) begin
        if (drop) begin
          dropping_r <= !in_end_of_message;
          if (in_end_of_message) begin
            write_offset_r <= '0;
          end
        end else if (in_end_of_message) begin
          write_offset_r <= '0;
          write_slot_r   <= next_slot(write_slot_r);
          entries_held_r <= entries_held_r + 1'b1;
        end else begin
          write_offset_r <= offset_inc;
        end
      end
      // message fully handed over: free its slot
      if (cmd.rd_emit && rd_last) begin
        read_slot_r    <= next_slot(read_slot_r);
        entries_held_r <= entries_held_r - 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_len_load) begin
      rd_len_r <= len_clamped;
      rd_idx_r <= '0;
    end else if (cmd.rd_emit) begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end
    if (load) begin
      out_status_r     <= ld_status;
      out_is_read_r    <= ld_is_read;
      out_byte_r       <= ld_byte;
      out_byte_valid_r <= ld_byte_valid;
      out_length_r     <= ld_length;
      out_last_r       <= ld_last;
    end
  end

  assign stat.empty    = (entries_held_r == '0);
  assign stat.out_free = out_free;
  assign stat.rd_last  = rd_last;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_is_read_data  = out_is_read_r;
  assign out_data_byte_out = out_byte_r;
  assign out_byte_valid    = out_byte_valid_r;
  assign out_length        = out_length_r;
  assign out_last          = out_last_r;

  a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entries_held_r <= CNT_W'(DEPTH))
    else $error("entry count beyond queue depth");

  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    write_offset_r <= LEN_W'(ELEMSZ))
    else $error("write offset beyond slot size");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_start || cmd.rd_emit) |-> (entries_held_r != '0))
    else $error("read of an empty queue");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_free)
    else $error("result register overwritten before transfer");

endmodule

/* design/bounded_message_fifo_unit.sv */
// top level of the bounded message fifo
// A circular queue of DEPTH message slots, each holding up to ELEMSZ bytes.
// Write items are taken one per cycle unless stalled; bytes beyond ELEMSZ are
// dropped and a whole message is dropped (status full) if the queue is full on
// any of its items. The closing write item returns one result with the
// accepted length. A read on an empty queue returns one empty status result in
// the cycle after it is taken. A read of a stored message occupies the block
// while it fetches the stored length from the length memory, primes the
// registered read of the byte memory and then returns one byte result per
// cycle while the output side takes them (one result for an empty message).
// Input is stalled while a read streams and while an untaken result is held.
module bounded_message_fifo_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [bmf_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                       in_byte_present,
  input  logic                       in_end_of_message,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic                       out_is_read_data,
  output logic [bmf_pkg::BYTE_W-1:0] out_data_byte_out,
  output logic                       out_byte_valid,
  output logic [bmf_pkg::LEN_W-1:0]  out_length,
  output logic                       out_last
);
  import bmf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmf_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_is_read_data  (out_is_read_data),
    .out_data_byte_out (out_data_byte_out),
    .out_byte_valid    (out_byte_valid),
    .out_length        (out_length),
    .out_last          (out_last)
  );

endmodule
